/* rtl/core/mm2_pkg.sv */
// ----------------------------------------------------------------------------
// mm2_pkg
// Shared types and constants for the 32-bit MurmurHash2 unit.
// ----------------------------------------------------------------------------
package mm2_pkg;

   localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
   localparam int          MIX_SHIFT   = 24;
   localparam int          FIN_SHIFT_A = 13;
   localparam int          FIN_SHIFT_B = 15;
   localparam logic [31:0] SEED_RESET  = 32'h9e37_79b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SEED_INDEX = 1'b0;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_BLOCK = 2'd1;
   localparam logic [1:0] KIND_TAIL  = 2'd2;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  kind;
      logic        first;
      logic [31:0] start;
      logic        last;
   } mm2_item_type;

   typedef struct packed {
      logic valid;
      logic full;
   } mm2_qstat_type;

endpackage

/* rtl/core/murmur2_hash_32_unit.sv */
// ----------------------------------------------------------------------------
// murmur2_hash_32_unit
// Streaming 32-bit MurmurHash2 over little-endian key words.
// ----------------------------------------------------------------------------
//  port group   dir   handshake          carries
//  req_*        in    valid / stall      one key word, byte count, first/last
//  rsp_*        out   valid / stall      finished hash of a key
//  csr_*        in    APB write/read     seed register at address 0
//
//  Back end per word: IDLE K1 K2 HB (full), IDLE TAIL (tail), IDLE (empty);
//  a last word adds avalanche F1 F2. All limited by the single shared 32x32
//  constant multiplier. A 2-entry queue decouples front and back.
//  Synchronous reset; seed resets to 0x9e3779b1, running hash to zero.
//  A stalled result holds in the output register and the back end waits.
module murmur2_hash_32_unit import mm2_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [31:0]           req_data_word,
   input  logic [2:0]            req_valid_bytes,
   input  logic                  req_first_item,
   input  logic [31:0]           req_key_length,
   input  logic                  req_last_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_hash_value
);

   mm2_item_type  push_item, head_item;
   mm2_qstat_type qstat;
   logic          q_push, q_pop;

   mm2_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_first_item  (req_first_item),
      .req_key_length  (req_key_length),
      .req_last_item   (req_last_item),
      .q_full          (qstat.full),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   mm2_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (qstat)
   );

   mm2_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_item      (head_item),
      .qstat          (qstat),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

/* rtl/core/mm2_front.sv */
// ----------------------------------------------------------------------------
// mm2_front
// Seed register, APB decode and classification of incoming key words.
// ----------------------------------------------------------------------------
module mm2_front import mm2_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [31:0]           req_data_word,
   input  logic [2:0]            req_valid_bytes,
   input  logic                  req_first_item,
   input  logic [31:0]           req_key_length,
   input  logic                  req_last_item,
   input  logic                  q_full,
   output logic                  q_push,
   output mm2_item_type          q_item
);

   logic [31:0] seed_ff, seed_in;
   logic        reg_index;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1];
   assign csr_pready = 1'b1;

   always_comb begin
      seed_in = seed_ff;
      if (csr_psel && csr_penable && csr_pwrite && (reg_index == REG_SEED_INDEX)) begin
         seed_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign csr_prdata = (reg_index == REG_SEED_INDEX) ? seed_ff : '0;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.first = req_first_item;
      q_item.last  = req_last_item;
      q_item.start = seed_ff ^ req_key_length;
      q_item.word  = req_data_word;
      q_item.kind  = KIND_NONE;
      unique case (req_valid_bytes) inside
         3'd0: begin
            q_item.kind = KIND_NONE;
         end
         3'd1: begin
            q_item.kind = KIND_TAIL;
            q_item.word = {24'd0, req_data_word[7:0]};
         end
         3'd2: begin
            q_item.kind = KIND_TAIL;
            q_item.word = {16'd0, req_data_word[15:0]};
         end
         3'd3: begin
            q_item.kind = KIND_TAIL;
            q_item.word = {8'd0, req_data_word[23:0]};
         end
         [3'd4:3'd7]: begin
            q_item.kind = KIND_BLOCK;
         end
         default: begin
            q_item.kind = KIND_NONE;
         end
      endcase
   end

endmodule

/* rtl/core/mm2_queue.sv */
// ----------------------------------------------------------------------------
// mm2_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module mm2_queue import mm2_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mm2_item_type  push_item,
   input  logic          pop,
   output mm2_item_type  head_item,
   output mm2_qstat_type stat
);

   mm2_item_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && stat.valid;
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/mm2_back.sv */
// ----------------------------------------------------------------------------
// mm2_back
// Mixing sequencer around one shared constant multiplier, plus result register.
// ----------------------------------------------------------------------------
module mm2_back import mm2_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  mm2_item_type  head_item,
   input  mm2_qstat_type qstat,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [31:0]   rsp_hash_value
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_K1   = 3'd1;
   localparam logic [2:0] ST_K2   = 3'd2;
   localparam logic [2:0] ST_HB   = 3'd3;
   localparam logic [2:0] ST_TAIL = 3'd4;
   localparam logic [2:0] ST_F1   = 3'd5;
   localparam logic [2:0] ST_F2   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] k_ff, k_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_hash_ff, rsp_hash_in;
   logic [31:0] mul_a, prod;
   logic        out_free;

   assign prod     = mul_a * MIX_MUL;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hash_in  = rsp_hash_ff;
      mul_a        = hash_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (qstat.valid) begin
               q_pop   = 1'b1;
               k_in    = head_item.word;
               last_in = head_item.last;
               if (head_item.first) begin
                  hash_in = head_item.start;
               end
               if (head_item.kind == KIND_BLOCK) begin
                  state_in = ST_K1;
               end else if (head_item.kind == KIND_TAIL) begin
                  state_in = ST_TAIL;
               end else if (head_item.last) begin
                  state_in = ST_F1;
               end
            end
         end
         ST_K1: begin
            mul_a    = k_ff;
            k_in     = prod;
            state_in = ST_K2;
         end
         ST_K2: begin
            mul_a    = k_ff ^ (k_ff >> MIX_SHIFT);
            k_in     = prod;
            state_in = ST_HB;
         end
         ST_HB: begin
            mul_a    = hash_ff;
            hash_in  = prod ^ k_ff;
            state_in = last_ff ? ST_F1 : ST_IDLE;
         end
         ST_TAIL: begin
            mul_a    = hash_ff ^ k_ff;
            hash_in  = prod;
            state_in = last_ff ? ST_F1 : ST_IDLE;
         end
         ST_F1: begin
            mul_a    = hash_ff ^ (hash_ff >> FIN_SHIFT_A);
            hash_in  = prod;
            state_in = ST_F2;
         end
         ST_F2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = hash_ff ^ (hash_ff >> FIN_SHIFT_B);
               hash_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

/* rtl/core/mm2_checker.sv */
// ----------------------------------------------------------------------------
// mm2_checker
// Port-level checks for the MurmurHash2 unit, bound to the top level.
// ----------------------------------------------------------------------------
module mm2_checker import mm2_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [31:0]           rsp_hash_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_hash_value))
      else $error("stalled result changed");

   // pipeline depth: a word must pass the queue and the back-end states before any result
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3))
      else $error("result too soon after reset");

   a_seed_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
         && (csr_paddr[CSR_ADDR_W-1] == REG_SEED_INDEX)
      |=> (csr_paddr[CSR_ADDR_W-1] != REG_SEED_INDEX) || (csr_prdata == $past(csr_pwdata)))
      else $error("seed readback mismatch");

endmodule

bind murmur2_hash_32_unit mm2_checker u_mm2_checker (.*);

/* sim/tb_murmur2_hash_32_unit.sv */
// ----------------------------------------------------------------------------
// tb_murmur2_hash_32_unit
// Self-checking bench for the streaming 32-bit MurmurHash2 unit. Key words are
// queued by a stimulus process and driven on req_* by a clocked driver. A
// clocked monitor folds every accepted word into a local hash model and checks
// each rsp_* hash in order. The seed register is reprogrammed over APB between
// phases, with random idles on both sides and one stretch without idles.
// ----------------------------------------------------------------------------
module tb_murmur2_hash_32_unit;
   import mm2_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = 3'd4;
   localparam int                    DRAIN_CYCLES = 40;

   typedef struct {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        first;
      logic [31:0] len;
      logic        last;
   } key_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [31:0]           req_data_word = '0;
   logic [2:0]            req_valid_bytes = '0;
   logic                  req_first_item = 1'b0;
   logic [31:0]           req_key_length = '0;
   logic                  req_last_item = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [31:0]           rsp_hash_value;

   key_word_type word_queue[$];
   logic [31:0]  hash_expect[$];
   key_word_type drive_word;
   logic [31:0]  seed_state;
   logic [31:0]  hash_state;
   logic [31:0]  next_hash;
   logic [31:0]  want_hash;
   logic         req_taken = 1'b0;
   int           idle_pct = 31;
   int           words_queued = 0;
   int           words_accepted = 0;
   int           hashes_checked = 0;
   int           seeds_used = 0;
   int           errors = 0;

   murmur2_hash_32_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_first_item  (req_first_item),
      .req_key_length  (req_key_length),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hash_value  (rsp_hash_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("%0t timeout waiting on the unit", $time);
      $display("murmur2_hash_32_unit test failed");
      $finish;
   end

   // Folds one word into the running hash; returns 1 with the digest on a last word.
   function automatic bit murmur_absorb(input key_word_type w, output logic [31:0] digest);
      logic [31:0] h;
      logic [31:0] k;
      logic [31:0] mask;
      int unsigned cnt;
      cnt = (w.nbytes > 3'd4) ? 4 : w.nbytes;
      h = w.first ? (seed_state ^ w.len) : hash_state;
      if (cnt == 4) begin
         k = w.data * MIX_MUL;
         k = k ^ (k >> MIX_SHIFT);
         k = k * MIX_MUL;
         h = (h * MIX_MUL) ^ k;
      end else if (cnt != 0) begin
         mask = (32'h1 << (8 * cnt)) - 32'h1;
         h = (h ^ (w.data & mask)) * MIX_MUL;
      end
      digest = 32'h0;
      if (w.last) begin
         h = h ^ (h >> FIN_SHIFT_A);
         h = h * MIX_MUL;
         digest = h ^ (h >> FIN_SHIFT_B);
         hash_state = 32'h0;
         return 1'b1;
      end
      hash_state = h;
      return 1'b0;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (word_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            drive_word = word_queue.pop_front();
            req_valid       <= 1'b1;
            req_data_word   <= drive_word.data;
            req_valid_bytes <= drive_word.nbytes;
            req_first_item  <= drive_word.first;
            req_key_length  <= drive_word.len;
            req_last_item   <= drive_word.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            words_accepted++;
            if (murmur_absorb('{req_data_word, req_valid_bytes, req_first_item,
                                req_key_length, req_last_item}, next_hash))
               hash_expect.push_back(next_hash);
         end
         if (rsp_valid && !rsp_stall) begin
            if (hash_expect.size() == 0) begin
               errors++;
               $display("%0t unexpected hash: expected none, actual %08h",
                        $time, rsp_hash_value);
            end else begin
               want_hash = hash_expect.pop_front();
               hashes_checked++;
               if (rsp_hash_value !== want_hash) begin
                  errors++;
                  $display("%0t hash_value mismatch: expected %08h, actual %08h",
                           $time, want_hash, rsp_hash_value);
               end
            end
         end
      end
   end

   task automatic push_word(input logic [31:0] data, input logic [2:0] nbytes,
                            input logic first, input logic [31:0] len, input logic last);
      word_queue.push_back('{data, nbytes, first, len, last});
      words_queued++;
   endtask

   task automatic wait_quiet();
      @(posedge clock);
      while (words_accepted != words_queued) @(posedge clock);
      while (hash_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == SEED_ADDR) seed_state = data;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check_seed();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= SEED_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== seed_state) begin
         errors++;
         $display("%0t seed readback mismatch: expected %08h, actual %08h",
                  $time, seed_state, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Well-formed key: full words, then a last word with 0..4 bytes (rarely 5..7).
   task automatic queue_key(output int counted);
      int          n_words;
      int unsigned tail;
      int unsigned nb;
      logic [31:0] klen;
      n_words = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      tail = ($urandom_range(19) == 0) ? $urandom_range(7, 5) : $urandom_range(4);
      klen = 4 * (n_words - 1) + ((tail > 4) ? 4 : tail);
      if ($urandom_range(4) == 0) klen = $urandom();
      for (int i = 0; i < n_words; i++) begin
         if (i == n_words - 1) nb = tail;
         else nb = ($urandom_range(15) == 0) ? $urandom_range(7, 5) : 4;
         push_word($urandom(), 3'(nb), i == 0, klen, i == n_words - 1);
      end
      counted = n_words;
   endtask

   task automatic queue_noise(output int counted);
      logic [2:0] nb;
      logic       first;
      logic       last;
      nb    = 3'($urandom_range(7));
      first = 1'($urandom_range(1));
      last  = ($urandom_range(3) == 0);
      push_word($urandom(), nb, first, $urandom(), last);
      counted = (nb == 3'd0 && !first && !last) ? 0 : 1;
   endtask

   task automatic run_phase(input logic [31:0] seed, input int target, input int idle);
      int  planned;
      int  got;
      bit  paused;
      planned = 0;
      paused  = 1'b0;
      wait_quiet();
      csr_write(SEED_ADDR, seed);
      csr_write(UNUSED_ADDR, $urandom());
      csr_check_seed();
      seeds_used++;
      idle_pct = idle;
      while (planned < target) begin
         if ($urandom_range(99) < 85) queue_key(got);
         else queue_noise(got);
         planned += got;
         if (!paused && planned >= target / 2) begin
            paused = 1'b1;
            wait_quiet();
         end
      end
   endtask

   initial begin
      seed_state = SEED_RESET;
      hash_state = 32'h0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_check_seed();
      seeds_used++;
      // words before any first word continue from the zero hash
      push_word(32'hffff_ffff, 3'd4, 1'b0, 32'h0, 1'b0);
      push_word(32'hffff_ffff, 3'd3, 1'b0, 32'h0, 1'b1);
      // single-word keys
      push_word(32'h0000_0000, 3'd4, 1'b1, 32'h4, 1'b1);
      push_word(32'hffff_ffff, 3'd4, 1'b1, 32'hffff_ffff, 1'b1);
      push_word(32'h0000_0000, 3'd0, 1'b1, 32'h0, 1'b1);
      push_word(32'hffff_ffff, 3'd1, 1'b1, 32'h1, 1'b1);
      push_word(32'hffff_ffff, 3'd2, 1'b1, 32'h2, 1'b1);
      push_word(32'ha5a5_a5a5, 3'd3, 1'b1, 32'h3, 1'b1);
      // byte counts above four mix as full words
      push_word(32'hdead_beef, 3'd5, 1'b1, 32'h4, 1'b1);
      push_word(32'hdead_beef, 3'd6, 1'b1, 32'h4, 1'b1);
      push_word(32'hdead_beef, 3'd7, 1'b1, 32'h4, 1'b1);
      // short word in mid-key, then a key that ends in a short word
      push_word(32'hcafe_f00d, 3'd2, 1'b1, 32'h6, 1'b0);
      push_word(32'h0123_4567, 3'd4, 1'b0, 32'h6, 1'b1);
      push_word(32'h6463_6261, 3'd4, 1'b1, 32'h7, 1'b0);
      push_word(32'h0067_6665, 3'd3, 1'b0, 32'h7, 1'b1);
      // empty word inside a key, and an empty last word
      push_word(32'hffff_ffff, 3'd4, 1'b1, 32'h8, 1'b0);
      push_word(32'hffff_ffff, 3'd0, 1'b0, 32'h8, 1'b0);
      push_word(32'hffff_ffff, 3'd4, 1'b0, 32'h8, 1'b1);
      push_word(32'h0000_0000, 3'd0, 1'b0, 32'h0, 1'b1);
      // a first word in mid-key restarts the hash
      push_word(32'h1111_1111, 3'd4, 1'b1, 32'h8, 1'b0);
      push_word(32'h2222_2222, 3'd4, 1'b1, 32'h4, 1'b1);

      run_phase(32'h0000_0000, 430, 31);
      run_phase(32'hffff_ffff, 430, 31);
      run_phase($urandom(), 430, 0);
      run_phase($urandom(), 430, 31);
      wait_quiet();

      $display("Coverage: %0d words in, %0d hashes compared, %0d seed settings",
               words_accepted, hashes_checked, seeds_used);
      $display("Mix of full, tail, empty and oversized words; stalls and idles on both sides");
      if (errors == 0) begin
         $display("murmur2_hash_32_unit test passed");
      end else begin
         $display("murmur2_hash_32_unit test failed");
      end
      $finish;
   end

endmodule
